// ===== design/tgcs_pkg.sv =====
// tgcs_pkg: shared constants, types and helpers of the toroidal grid cell store.
// Used by tgcs_mod_serial and toroidal_grid_cell_store.
// No dependencies.
package tgcs_pkg;

  // Grid geometry and cell storage
  localparam int MAX_SIDE    = 64;
  localparam int CELL_BITS   = 8;
  localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Remainder holds 0..MAX_SIDE-1; side holds 1..MAX_SIDE
  localparam int REM_W  = $clog2(MAX_SIDE);
  localparam int SIDE_W = REM_W + 1;

  // Field widths of the stream payload
  localparam int COORD_W  = 16;
  localparam int CNT_W    = $clog2(COORD_W);
  localparam int DATA_W   = 8;
  localparam int INDEX_W  = 12;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  // Reset value of both grid side registers
  localparam logic [CFG_W-1:0] GRID_RESET = CFG_W'(64);

  typedef logic [CELL_BITS-1:0] cell_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [REM_W-1:0]     rem_t;
  typedef logic [SIDE_W-1:0]    side_t;
  typedef logic [COORD_W-1:0]   coord_t;
  typedef logic [CFG_W-1:0]     cfg_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1
  } cfg_reg_e;

  // Request kinds carried in tuser
  typedef enum logic {
    REQ_READ  = 1'b0,
    REQ_WRITE = 1'b1
  } req_type_e;

  // Sequencer states of the top level
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRAP,
    ST_ACCESS,
    ST_RESULT
  } state_e;

  // Status of a serial modulo unit toward the sequencer
  typedef struct packed {
    logic done;
    rem_t value;
  } mod_res_t;

  // Side register value as used: zero counts as one, clamp to MAX_SIDE
  function automatic side_t eff_side(cfg_t v);
    side_t s;
    if (v == '0) begin
      s = side_t'(1);
    end else if (int'(v) > MAX_SIDE) begin
      s = side_t'(MAX_SIDE);
    end else begin
      s = side_t'(v);
    end
    return s;
  endfunction

endpackage

// ===== design/tgcs_ram.sv =====
// tgcs_ram: generic single-port RAM with registered read data.
// Standalone; no package dependency.
module tgcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One access per cycle; read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/tgcs_mod_serial.sv =====
// tgcs_mod_serial: bit-serial Euclidean modulo of a signed coordinate by a side.
// Restoring remainder, one dividend bit per cycle. Depends on tgcs_pkg.
module tgcs_mod_serial (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  tgcs_pkg::coord_t   dividend_i,
  input  tgcs_pkg::side_t    divisor_i,
  output tgcs_pkg::mod_res_t res_o
);

  tgcs_pkg::coord_t shift_q, shift_d;
  tgcs_pkg::rem_t   rem_q, rem_d;
  tgcs_pkg::side_t  div_q;
  logic             neg_q;
  logic [tgcs_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             last_step;
  tgcs_pkg::side_t  trial;
  tgcs_pkg::side_t  wrapped;

  // Magnitude goes in MSB first; sign kept for the final fixup
  assign last_step = busy_q && (cnt_q == tgcs_pkg::CNT_W'(tgcs_pkg::COORD_W - 1));
  assign trial     = {rem_q, shift_q[tgcs_pkg::COORD_W-1]};

  always_comb begin
    shift_d = shift_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = last_step;
    if (start_i) begin
      shift_d = dividend_i[tgcs_pkg::COORD_W-1] ? (~dividend_i + 1'b1) : dividend_i;
      rem_d   = '0;
      cnt_d   = '0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      shift_d = {shift_q[tgcs_pkg::COORD_W-2:0], 1'b0};
      rem_d   = (trial >= div_q) ? tgcs_pkg::rem_t'(trial - div_q) : tgcs_pkg::rem_t'(trial);
      cnt_d   = cnt_q + 1'b1;
      busy_d  = !last_step;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
    if (start_i) begin
      div_q <= divisor_i;
      neg_q <= dividend_i[tgcs_pkg::COORD_W-1];
    end
  end

  // Negative input with a nonzero remainder wraps from the far edge
  assign wrapped = div_q - tgcs_pkg::side_t'(rem_q);

  assign res_o.done  = done_q;
  assign res_o.value = (neg_q && (rem_q != '0)) ? tgcs_pkg::rem_t'(wrapped) : rem_q;

endmodule

// ===== design/toroidal_grid_cell_store.sv =====
// toroidal_grid_cell_store: cell store on a torus; wraps coordinates, reads or writes a cell.
// Each request goes through a 16-bit serial modulo of x and y in two parallel bit-serial
// units, index multiply, RAM access and output load. One request at a time: a new one
// is accepted only in idle, once the previous result is loaded into the output register,
// which waits while a held result is not taken. Reset: asynchronous active-low clears
// control and sets both grid sides to 64; cell contents are undefined until written.
// Depends on tgcs_pkg, tgcs_mod_serial, tgcs_ram.
module toroidal_grid_cell_store (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tgcs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  tgcs_pkg::cfg_t                 cfg_data_i,

  // Request stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [tgcs_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // x_coord, y_coord, write_data
  input  logic                                  s_axis_tuser,  // req_type

  // Result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [tgcs_pkg::OUT_TDATA_W-1:0]      m_axis_tdata   // read_data, cell_index, pad
);

  tgcs_pkg::state_e   state_q, state_d;
  tgcs_pkg::cfg_t     grid_width_q, grid_height_q;
  tgcs_pkg::side_t    side_w, side_h;
  tgcs_pkg::mod_res_t res_x, res_y;
  tgcs_pkg::coord_t   in_x, in_y;
  logic [tgcs_pkg::DATA_W-1:0] in_wdata;
  logic               req_write_q;
  tgcs_pkg::cell_t    wdata_q;
  tgcs_pkg::addr_t    idx_q, idx_d;
  tgcs_pkg::cell_t    ram_rdata;
  logic               out_valid_q;
  logic [tgcs_pkg::DATA_W-1:0]  out_rd_q;
  logic [tgcs_pkg::INDEX_W-1:0] out_idx_q;
  logic               in_fire;
  logic               start;
  logic               idx_load;
  logic               ram_en;
  logic               out_load;

  // Payload unpacking
  assign in_x     = s_axis_tdata[15:0];
  assign in_y     = s_axis_tdata[31:16];
  assign in_wdata = s_axis_tdata[39:32];

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= tgcs_pkg::GRID_RESET;
      grid_height_q <= tgcs_pkg::GRID_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tgcs_pkg::CFG_GRID_WIDTH:  grid_width_q  <= cfg_data_i;
        tgcs_pkg::CFG_GRID_HEIGHT: grid_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign side_w = tgcs_pkg::eff_side(grid_width_q);
  assign side_h = tgcs_pkg::eff_side(grid_height_q);

  // Serial modulo units, x and y side by side
  tgcs_mod_serial u_mod_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .dividend_i (in_x),
    .divisor_i  (side_w),
    .res_o      (res_x)
  );

  tgcs_mod_serial u_mod_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .dividend_i (in_y),
    .divisor_i  (side_h),
    .res_o      (res_y)
  );

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tgcs_pkg::ST_IDLE:   if (s_axis_tvalid) state_d = tgcs_pkg::ST_WRAP;
      tgcs_pkg::ST_WRAP:   if (res_x.done) state_d = tgcs_pkg::ST_ACCESS;
      tgcs_pkg::ST_ACCESS: state_d = tgcs_pkg::ST_RESULT;
      tgcs_pkg::ST_RESULT: if (!out_valid_q || m_axis_tready) state_d = tgcs_pkg::ST_IDLE;
      default:             state_d = tgcs_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    idx_load      = 1'b0;
    ram_en        = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      tgcs_pkg::ST_IDLE:   s_axis_tready = 1'b1;
      tgcs_pkg::ST_WRAP:   idx_load      = res_x.done;
      tgcs_pkg::ST_ACCESS: ram_en        = 1'b1;
      tgcs_pkg::ST_RESULT: out_load      = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign start   = in_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tgcs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Request latch
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_write_q <= (s_axis_tuser == tgcs_pkg::REQ_WRITE);
      wdata_q     <= tgcs_pkg::cell_t'(in_wdata);
    end
  end

  // Linear index: wrapped x times height plus wrapped y
  assign idx_d = tgcs_pkg::addr_t'(res_x.value) * tgcs_pkg::addr_t'(side_h)
               + tgcs_pkg::addr_t'(res_y.value);

  always_ff @(posedge clk_i) begin
    if (idx_load) begin
      idx_q <= idx_d;
    end
  end

  // Cell storage
  tgcs_ram #(
    .WIDTH (tgcs_pkg::CELL_BITS),
    .DEPTH (tgcs_pkg::STORE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (req_write_q),
    .addr_i  (idx_q),
    .wdata_i (wdata_q),
    .rdata_o (ram_rdata)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rd_q  <= req_write_q ? '0 : tgcs_pkg::DATA_W'(ram_rdata);
      out_idx_q <= tgcs_pkg::INDEX_W'(idx_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_idx_q, out_rd_q};

endmodule
